### rtl/core/scre_pkg.sv
// ----------------------------------------------------------------------------
// scre_pkg: shared types and constants of the sound register block
// Item modes, event kinds, sequencer states and register offsets.
// ----------------------------------------------------------------------------
`default_nettype none
package scre_pkg;

    localparam int unsigned PatternBytes = 16;
    localparam int unsigned NumRegs      = 14;
    localparam int unsigned TicksPerStep = 65536;

    // item modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // event kinds
    localparam logic [2:0] EV_READ   = 3'd0;
    localparam logic [2:0] EV_FREQ   = 3'd1;
    localparam logic [2:0] EV_VOLUME = 3'd2;
    localparam logic [2:0] EV_ENABLE = 3'd3;
    localparam logic [2:0] EV_WAVE   = 3'd4;

    // register offsets
    localparam logic [5:0] OFF_CH1_ENV  = 6'h12;
    localparam logic [5:0] OFF_CH1_TRIG = 6'h14;
    localparam logic [5:0] OFF_CH2_ENV  = 6'h17;
    localparam logic [5:0] OFF_CH2_TRIG = 6'h19;
    localparam logic [5:0] OFF_CH3_EN   = 6'h1A;
    localparam logic [5:0] OFF_CH3_TRIG = 6'h1E;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT_FREQ,
        ST_EMIT_VOL,
        ST_EMIT_WAVE,
        ST_TICK0,
        ST_TICK1,
        ST_EMIT_ONE
    } state_t;

    // divider control handshake
    typedef struct packed {
        logic        start;
        logic [17:0] dividend;
        logic [11:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [17:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

### rtl/core/scre_divider.sv
// ----------------------------------------------------------------------------
// scre_divider: restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module scre_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scre_pkg::div_req_t req,
    output scre_pkg::div_rsp_t     rsp
);
    logic [17:0] quot_reg, quot_next;
    logic [12:0] rem_reg, rem_next;
    logic [11:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [12:0] trial;

    // one shift-subtract step per cycle
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[11:0], quot_reg[17]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 5'd18;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[16:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[16:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;
endmodule
`default_nettype wire

### rtl/core/sound_channel_registers_envelope.sv
// ----------------------------------------------------------------------------
// sound_channel_registers_envelope: sound channel registers and envelopes
// Register file for channels 1-3, wave pattern store and two envelopes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: mode, reg_offset, write_data, tick_count.
//   m_axis carries result items: event_kind, channel, event_value,
//   pattern_index in tdata and tlast on the final result of an item.
//   The block takes one item at a time; s_axis_tready is high only when
//   it is idle with the output register empty. A read result goes through
//   ST_EMIT_ONE to the output register. A trigger write runs the shared
//   restoring divider for the frequency, then emits frequency, volume
//   and, for channel 3, the 16 pattern bytes one per cycle while
//   m_axis_tready stays high. Ticks step both envelopes in turn through
//   one shared add and compare. Writes with no event stay in ST_IDLE.
//   Every result waits in the output register while m_axis_tready is low;
//   the sequencer holds until it is taken.
//   Reset clears all registers, the pattern store and the envelopes.
// ----------------------------------------------------------------------------
`default_nettype none
module sound_channel_registers_envelope (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // mode[1:0], reg_offset[7:2], write_data[15:8], tick_count[25:16], 0
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_kind[2:0], channel[4:3], event_value[22:5], pattern_index[26:23]
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    scre_pkg::state_t state_reg, state_next;

    logic [7:0]  regs_reg [scre_pkg::NumRegs];
    logic [7:0]  wave_reg [scre_pkg::PatternBytes];
    logic [3:0]  vol_reg [2];
    logic        inc_reg [2];
    logic [2:0]  per_reg [2];
    logic [19:0] tcnt_reg [2];

    logic [1:0]  in_mode;
    logic [5:0]  in_off;
    logic [7:0]  in_data;
    logic [9:0]  in_ticks;
    logic [1:0]  ch_reg, ch_next;
    logic [3:0]  idx_reg, idx_next;
    logic [9:0]  ticks_reg, ticks_next;

    logic        ov_reg, ov_next;
    logic [2:0]  okind_reg, okind_next;
    logic [1:0]  och_reg, och_next;
    logic [17:0] oval_reg, oval_next;
    logic [3:0]  oidx_reg, oidx_next;
    logic        olast_reg, olast_next;

    scre_pkg::div_req_t div_req;
    scre_pkg::div_rsp_t div_rsp;
    logic [17:0] freq_reg, freq_next;

    logic        slot_ok;
    logic [3:0]  slot;
    logic        wave_ok;
    logic        accept;
    logic        out_free;

    // shared envelope unit
    logic        env_sel;
    logic [19:0] env_sum;
    logic [19:0] env_limit;
    logic        env_step;
    logic [3:0]  env_vol_new;

    assign in_mode  = s_axis_tdata[1:0];
    assign in_off   = s_axis_tdata[7:2];
    assign in_data  = s_axis_tdata[15:8];
    assign in_ticks = s_axis_tdata[25:16];
    assign s_axis_tready = (state_reg == scre_pkg::ST_IDLE) && !ov_reg;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !ov_reg || m_axis_tready;

    // offset decode
    always_comb
    begin
        slot_ok = 1'b0;
        slot    = '0;
        if (in_off >= 6'h10 && in_off <= 6'h14)
        begin
            slot_ok = 1'b1;
            slot    = 4'(in_off - 6'h10);
        end
        else if (in_off >= 6'h16 && in_off <= 6'h1E)
        begin
            slot_ok = 1'b1;
            slot    = 4'(in_off - 6'h11);
        end
        wave_ok = (in_off[5:4] == 2'b11);
    end

    assign env_sel     = (state_reg == scre_pkg::ST_TICK1);
    assign env_sum     = tcnt_reg[env_sel] + 20'(ticks_reg);
    assign env_limit   = 20'(scre_pkg::TicksPerStep) * 20'(per_reg[env_sel]);
    assign env_step    = env_sum > env_limit;
    assign env_vol_new = inc_reg[env_sel]
                         ? ((vol_reg[env_sel] == 4'd15) ? 4'd15 : vol_reg[env_sel] + 4'd1)
                         : ((vol_reg[env_sel] == 4'd0) ? 4'd0 : vol_reg[env_sel] - 4'd1);

    scre_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        idx_next     = idx_reg;
        ticks_next   = ticks_reg;
        freq_next    = freq_reg;
        ov_next      = ov_reg && !m_axis_tready;
        okind_next   = okind_reg;
        och_next     = och_reg;
        oval_next    = oval_reg;
        oidx_next    = oidx_reg;
        olast_next   = olast_reg;
        div_req.start    = 1'b0;
        div_req.dividend = (ch_reg == 2'd3) ? 18'd65536 : 18'd131072;
        div_req.divisor  = 12'd2048 - {1'b0,
                           (ch_reg == 2'd1) ? regs_reg[4][2:0]
                           : (ch_reg == 2'd2) ? regs_reg[8][2:0] : regs_reg[13][2:0],
                           (ch_reg == 2'd1) ? regs_reg[3]
                           : (ch_reg == 2'd2) ? regs_reg[7] : regs_reg[12]};
        case (state_reg)
            scre_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ticks_next   = in_ticks;
                    case (in_mode)
                        scre_pkg::MODE_READ:
                        begin
                            okind_next = scre_pkg::EV_READ;
                            och_next   = 2'd0;
                            oidx_next  = '0;
                            oval_next  = slot_ok ? 18'(regs_reg[slot])
                                       : wave_ok ? 18'(wave_reg[in_off[3:0]]) : 18'd0;
                            olast_next = 1'b1;
                            state_next = scre_pkg::ST_EMIT_ONE;
                        end
                        scre_pkg::MODE_WRITE:
                        begin
                            if (in_off == scre_pkg::OFF_CH3_EN)
                            begin
                                okind_next = scre_pkg::EV_ENABLE;
                                och_next   = 2'd3;
                                oidx_next  = '0;
                                oval_next  = 18'(in_data[7]);
                                olast_next = 1'b1;
                                state_next = scre_pkg::ST_EMIT_ONE;
                            end
                            else if (in_data[7] && (in_off == scre_pkg::OFF_CH1_TRIG
                                     || in_off == scre_pkg::OFF_CH2_TRIG
                                     || in_off == scre_pkg::OFF_CH3_TRIG))
                            begin
                                ch_next = (in_off == scre_pkg::OFF_CH1_TRIG) ? 2'd1
                                        : (in_off == scre_pkg::OFF_CH2_TRIG) ? 2'd2 : 2'd3;
                                state_next = scre_pkg::ST_DIV_START;
                            end
                        end
                        scre_pkg::MODE_TICK:
                            state_next = scre_pkg::ST_TICK0;
                        default: ;
                    endcase
                end
            end
            scre_pkg::ST_DIV_START:
            begin
                div_req.start = 1'b1;
                state_next    = scre_pkg::ST_DIV_WAIT;
            end
            scre_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    freq_next  = div_rsp.quotient;
                    state_next = scre_pkg::ST_EMIT_FREQ;
                end
            end
            scre_pkg::ST_EMIT_FREQ:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = scre_pkg::EV_FREQ;
                    och_next   = ch_reg;
                    oval_next  = freq_reg;
                    oidx_next  = '0;
                    olast_next = 1'b0;
                    state_next = scre_pkg::ST_EMIT_VOL;
                end
            end
            scre_pkg::ST_EMIT_VOL:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = scre_pkg::EV_VOLUME;
                    och_next   = ch_reg;
                    oidx_next  = '0;
                    oval_next  = (ch_reg == 2'd1) ? 18'(vol_reg[0])
                               : (ch_reg == 2'd2) ? 18'(vol_reg[1])
                               : 18'(regs_reg[11][6:5]);
                    olast_next = (ch_reg != 2'd3);
                    idx_next   = '0;
                    state_next = (ch_reg == 2'd3) ? scre_pkg::ST_EMIT_WAVE
                                                  : scre_pkg::ST_IDLE;
                end
            end
            scre_pkg::ST_EMIT_WAVE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = scre_pkg::EV_WAVE;
                    och_next   = 2'd3;
                    oval_next  = 18'(wave_reg[idx_reg]);
                    oidx_next  = idx_reg;
                    olast_next = (idx_reg == 4'd15);
                    idx_next   = idx_reg + 4'd1;
                    if (idx_reg == 4'd15)
                        state_next = scre_pkg::ST_IDLE;
                end
            end
            scre_pkg::ST_TICK0,
            scre_pkg::ST_TICK1:
            begin
                // channel 1 result must leave before channel 2 is looked at
                if (out_free)
                begin
                    if (per_reg[env_sel] != 3'd0 && env_step)
                    begin
                        ov_next      = 1'b1;
                        okind_next   = scre_pkg::EV_VOLUME;
                        och_next     = env_sel ? 2'd2 : 2'd1;
                        oval_next    = 18'(env_vol_new);
                        oidx_next    = '0;
                        olast_next   = env_sel || per_reg[1] == 3'd0
                                       || !((tcnt_reg[1] + 20'(ticks_reg))
                                            > 20'(scre_pkg::TicksPerStep) * 20'(per_reg[1]));
                    end
                    state_next = env_sel ? scre_pkg::ST_IDLE : scre_pkg::ST_TICK1;
                end
            end
            scre_pkg::ST_EMIT_ONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    state_next = scre_pkg::ST_IDLE;
                end
            end
            default:
                state_next = scre_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scre_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
            for (int i = 0; i < scre_pkg::NumRegs; i++)
                regs_reg[i] <= '0;
            for (int i = 0; i < scre_pkg::PatternBytes; i++)
                wave_reg[i] <= '0;
            for (int i = 0; i < 2; i++)
            begin
                vol_reg[i]  <= '0;
                inc_reg[i]  <= 1'b0;
                per_reg[i]  <= '0;
                tcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            // register writes
            if (accept && in_mode == scre_pkg::MODE_WRITE)
            begin
                if (slot_ok)
                    regs_reg[slot] <= in_data;
                else if (wave_ok)
                    wave_reg[in_off[3:0]] <= in_data;
                if (in_off == scre_pkg::OFF_CH1_ENV)
                begin
                    vol_reg[0] <= in_data[7:4];
                    inc_reg[0] <= in_data[3];
                    per_reg[0] <= in_data[2:0];
                end
                if (in_off == scre_pkg::OFF_CH2_ENV)
                begin
                    vol_reg[1] <= in_data[7:4];
                    inc_reg[1] <= in_data[3];
                    per_reg[1] <= in_data[2:0];
                end
                if (in_off == scre_pkg::OFF_CH1_TRIG && in_data[7])
                    tcnt_reg[0] <= '0;
                if (in_off == scre_pkg::OFF_CH2_TRIG && in_data[7])
                    tcnt_reg[1] <= '0;
            end
            // envelope step
            if ((state_reg == scre_pkg::ST_TICK0 || state_reg == scre_pkg::ST_TICK1)
                && out_free && per_reg[env_sel] != 3'd0)
            begin
                if (env_step)
                begin
                    tcnt_reg[env_sel] <= '0;
                    vol_reg[env_sel]  <= env_vol_new;
                end
                else
                    tcnt_reg[env_sel] <= env_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        idx_reg     <= idx_next;
        ticks_reg   <= ticks_next;
        freq_reg    <= freq_next;
        okind_reg   <= okind_next;
        och_reg     <= och_next;
        oval_reg    <= oval_next;
        oidx_reg    <= oidx_next;
        olast_reg   <= olast_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {5'd0, oidx_reg, oval_reg, och_reg, okind_reg};
    assign m_axis_tlast  = olast_reg;
endmodule
`default_nettype wire
